@@ design/ircf_pkg.sv @@
// shared constants and types for the infrared space coded frame encoder
`default_nettype none

package ircf_pkg;

   // field widths
   localparam int KEY_W      = 12;
   localparam int BT_W       = 8;
   localparam int GAP_W      = 5;
   localparam int SEG_W      = 11;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;

   // default code length
   localparam int NUM_BITS_DEF = 12;

   // register reset values
   localparam logic [BT_W-1:0]  BIT_TICKS_RST   = 8'd28;
   localparam logic [GAP_W-1:0] GAP_PERIODS_RST = 5'd30;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_BIT_TICKS   = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAP_PERIODS = 1'd1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEND   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd2;

   // one buffered request
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key_code;
   } req_item_type;

   // handoff between input stage and sequencer
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_out_type;

endpackage

`default_nettype wire

@@ design/ircf_if.sv @@
// channel interfaces for request, response and register write
`default_nettype none

interface ircf_req_if;
   import ircf_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [KEY_W-1:0]  key_code;
   modport source (output valid, output mode, output key_code, input ready);
   modport sink   (input valid, input mode, input key_code, output ready);
endinterface

interface ircf_rsp_if;
   import ircf_pkg::*;
   logic             valid;
   logic             ready;
   logic             carrier_on;
   logic [SEG_W-1:0] segment_ticks;
   logic             busy_res;
   modport source (output valid, output carrier_on, output segment_ticks,
                   output busy_res, input ready);
   modport sink   (input valid, input carrier_on, input segment_ticks,
                   input busy_res, output ready);
endinterface

interface ircf_csr_if;
   import ircf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

@@ design/ircf_csr.sv @@
// configuration registers: bit time and closing gap length
`default_nettype none

module ircf_csr
   import ircf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   ircf_csr_if.sink              csr_chan,
   output logic [BT_W-1:0]       bit_ticks,
   output logic [GAP_W-1:0]      gap_periods
);

   logic [BT_W-1:0]  bit_ticks_ff,   bit_ticks_in;
   logic [GAP_W-1:0] gap_periods_ff, gap_periods_in;
   logic             wr_en;

   // writes are always taken
   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;

   // register decode
   always_comb begin
      bit_ticks_in   = bit_ticks_ff;
      gap_periods_in = gap_periods_ff;
      if (wr_en) begin
         case (csr_chan.addr)
            CSR_BIT_TICKS:   bit_ticks_in   = csr_chan.data;
            CSR_GAP_PERIODS: gap_periods_in = csr_chan.data[GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff   <= BIT_TICKS_RST;
         gap_periods_ff <= GAP_PERIODS_RST;
      end else begin
         bit_ticks_ff   <= bit_ticks_in;
         gap_periods_ff <= gap_periods_in;
      end
   end

   assign bit_ticks   = bit_ticks_ff;
   assign gap_periods = gap_periods_ff;

endmodule

`default_nettype wire

@@ design/ircf_in_stage.sv @@
// input register holding one request ahead of the sequencer
`default_nettype none

module ircf_in_stage
   import ircf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   ircf_req_if.sink       req_chan,
   input  wire logic      take,
   output stage_out_type  stage_out
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         load;

   // room when empty or when the held request moves on this cycle
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in         = 1'b1;
         item_in.mode     = req_chan.mode;
         item_in.key_code = req_chan.key_code;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.item  = item_ff;

endmodule

`default_nettype wire

@@ design/ircf_seq.sv @@
// frame sequencer: phase machine, code shifter and response register
`default_nettype none

module ircf_seq
   import ircf_pkg::*;
#(
   parameter int NUM_BITS = NUM_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire stage_out_type    stage_out,
   input  wire logic [BT_W-1:0]  bit_ticks,
   input  wire logic [GAP_W-1:0] gap_periods,
   output logic                  take,
   ircf_rsp_if.source            rsp_chan
);

   localparam int IDX_W = $clog2(NUM_BITS + 1);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_PRE_A  = 4'd1,
      PH_PRE_B  = 4'd2,
      PH_BIT_A  = 4'd3,
      PH_BIT_B  = 4'd4,
      PH_IBIT_A = 4'd5,
      PH_IBIT_B = 4'd6,
      PH_STOP   = 4'd7,
      PH_WAIT   = 4'd8
   } phase_type;

   phase_type            phase_ff,   phase_in;
   logic [NUM_BITS-1:0]  shift_ff,   shift_in;
   logic [NUM_BITS-1:0]  held_ff,    held_in;
   logic [IDX_W-1:0]     idx_ff,     idx_in;
   logic [GAP_W-1:0]     gap_ff,     gap_in;
   logic                 carrier_ff, carrier_in;
   logic [SEG_W-1:0]     seg_ff,     seg_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [KEY_W+NUM_BITS-1:0] key_ext;
   logic [NUM_BITS-1:0]       key_trunc;
   logic [IDX_W:0]            idx_inc;
   logic                      idx_done;
   logic [GAP_W-1:0]          gap_inc;
   logic [SEG_W-1:0]          seg_one, seg_two, seg_four, seg_eight;

   // a request moves on when the response slot is free or being emptied
   assign take = stage_out.valid && (!rsp_valid_ff || rsp_chan.ready);

   // key code cut or widened to the code length
   assign key_ext   = {{NUM_BITS{1'b0}}, stage_out.item.key_code};
   assign key_trunc = key_ext[NUM_BITS-1:0];

   // segment lengths in ticks
   assign seg_one   = {3'b000, bit_ticks};
   assign seg_two   = {2'b00, bit_ticks, 1'b0};
   assign seg_four  = {1'b0, bit_ticks, 2'b00};
   assign seg_eight = {bit_ticks, 3'b000};

   assign idx_inc  = {1'b0, idx_ff} + {{IDX_W{1'b0}}, 1'b1};
   assign idx_done = (idx_inc >= (IDX_W + 1)'(NUM_BITS));
   assign gap_inc  = gap_ff + {{(GAP_W-1){1'b0}}, 1'b1};

   // next state for the request at the head of the input stage
   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      held_in    = held_ff;
      idx_in     = idx_ff;
      gap_in     = gap_ff;
      carrier_in = carrier_ff;
      seg_in     = seg_ff;
      if (take) begin
         case (stage_out.item.mode)
            MODE_TICK: begin
               case (phase_ff)
                  PH_IDLE: begin
                     carrier_in = 1'b0;
                  end
                  PH_PRE_A: begin
                     seg_in     = seg_eight;
                     carrier_in = 1'b1;
                     phase_in   = PH_PRE_B;
                  end
                  PH_PRE_B: begin
                     carrier_in = 1'b0;
                     shift_in   = held_ff;
                     phase_in   = PH_BIT_A;
                  end
                  PH_BIT_A, PH_IBIT_A, PH_STOP: begin
                     seg_in     = seg_one;
                     carrier_in = 1'b1;
                     case (phase_ff)
                        PH_BIT_A:  phase_in = PH_BIT_B;
                        PH_IBIT_A: phase_in = PH_IBIT_B;
                        default:   phase_in = PH_WAIT;
                     endcase
                  end
                  PH_BIT_B, PH_IBIT_B: begin
                     carrier_in = 1'b0;
                     seg_in     = shift_ff[NUM_BITS-1] ? seg_four : seg_two;
                     shift_in   = shift_ff << 1;
                     idx_in     = idx_inc[IDX_W-1:0];
                     if (idx_done) begin
                        if (phase_ff == PH_BIT_B) begin
                           // move on to the inverted copy
                           shift_in = ~held_ff;
                           idx_in   = '0;
                           phase_in = PH_IBIT_A;
                        end else begin
                           phase_in = PH_STOP;
                        end
                     end else begin
                        phase_in = (phase_ff == PH_BIT_B) ? PH_BIT_A : PH_IBIT_A;
                     end
                  end
                  PH_WAIT: begin
                     carrier_in = 1'b0;
                     seg_in     = seg_one;
                     gap_in     = gap_inc;
                     if (gap_inc >= gap_periods) begin
                        idx_in   = '0;
                        gap_in   = '0;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     carrier_in = 1'b0;
                     phase_in   = PH_IDLE;
                  end
               endcase
            end
            MODE_SEND: begin
               held_in = key_trunc;
               if (key_trunc != '0 && phase_ff == PH_IDLE) begin
                  phase_in = PH_PRE_A;
               end
            end
            MODE_REPEAT: begin
               if (held_ff != '0 && phase_ff == PH_IDLE) begin
                  phase_in = PH_PRE_A;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= '0;
         held_ff      <= '0;
         idx_ff       <= '0;
         gap_ff       <= '0;
         carrier_ff   <= 1'b0;
         seg_ff       <= {3'b000, BIT_TICKS_RST};
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         shift_ff     <= shift_in;
         held_ff      <= held_in;
         idx_ff       <= idx_in;
         gap_ff       <= gap_in;
         carrier_ff   <= carrier_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // state only changes with a new response, so it doubles as the payload
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.carrier_on    = carrier_ff;
   assign rsp_chan.segment_ticks = seg_ff;
   assign rsp_chan.busy_res      = (phase_ff != PH_IDLE);

endmodule

`default_nettype wire

@@ design/ir_space_coded_frame_encoder.sv @@
// top level of the infrared space coded frame encoder
//
//   channel    dir  payload                                    handshake
//   req_chan   in   mode, key_code                             valid / ready
//   rsp_chan   out  carrier_on, segment_ticks, busy_res        valid / ready
//   csr_chan   in   addr (0 bit_ticks, 1 gap_periods), data    valid / ready
//
// an accepted request passes through the input register, then the phase machine
// updates its registers, which form the response
// one request per cycle is sustained while rsp_chan is ready; the input register refills in the same
// cycle the response slot is emptied, and a stalled response holds both sides
// reset is synchronous and active high; config writes are always ready
`default_nettype none

module ir_space_coded_frame_encoder
   import ircf_pkg::*;
#(
   parameter int NUM_BITS = NUM_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ircf_req_if.sink    req_chan,
   ircf_rsp_if.source  rsp_chan,
   ircf_csr_if.sink    csr_chan
);

   logic [BT_W-1:0]  bit_ticks;
   logic [GAP_W-1:0] gap_periods;
   stage_out_type    stage_out;
   logic             take;

   // configuration registers
   ircf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_chan    (csr_chan),
      .bit_ticks   (bit_ticks),
      .gap_periods (gap_periods)
   );

   // input register
   ircf_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .take      (take),
      .stage_out (stage_out)
   );

   // frame sequencer and response register
   ircf_seq #(
      .NUM_BITS (NUM_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .stage_out   (stage_out),
      .bit_ticks   (bit_ticks),
      .gap_periods (gap_periods),
      .take        (take),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

@@ tb/sv/ir_space_coded_frame_encoder_test.sv @@
// self-checking testbench for the infrared space coded frame encoder
`timescale 1ns / 1ps

module ir_space_coded_frame_encoder_test;
   import ircf_pkg::*;

   localparam int CODE_BITS   = NUM_BITS_DEF;
   localparam int SETTLE      = 4;
   localparam int HOLD_CYCLES = 60;
   localparam int QUIET_LIMIT = 1000;
   localparam int PHASE_ITEMS = 180;

   // unused mode code, expected to be ignored
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // frame sequencer steps
   typedef enum logic [3:0] {
      FR_IDLE, FR_PRE_MARK, FR_PRE_SPACE, FR_BIT_MARK, FR_BIT_SPACE,
      FR_INV_MARK, FR_INV_SPACE, FR_STOP, FR_GAP
   } frame_step_type;

   // one segment report
   typedef struct packed {
      logic             carrier;
      logic [SEG_W-1:0] segment;
      logic             busy;
   } segment_report_type;

   // segment predictor and queue of pending reports
   class frame_scoreboard;
      logic [BT_W-1:0]      bit_ticks;
      logic [GAP_W-1:0]     gap_periods;
      frame_step_type       phase;
      logic [CODE_BITS-1:0] shift_word;
      logic [CODE_BITS-1:0] held_code;
      logic [4:0]           bit_index;
      logic [GAP_W-1:0]     gap_count;
      logic                 carrier;
      logic [SEG_W-1:0]     segment;
      segment_report_type   pending_reports[$];
      int                   errors;
      int                   compared;
      int                   frames_started;

      function new();
         bit_ticks      = BIT_TICKS_RST;
         gap_periods    = GAP_PERIODS_RST;
         phase          = FR_IDLE;
         shift_word     = '0;
         held_code      = '0;
         bit_index      = '0;
         gap_count      = '0;
         carrier        = 1'b0;
         segment        = SEG_W'(BIT_TICKS_RST);
         errors         = 0;
         compared       = 0;
         frames_started = 0;
      endfunction

      function void configure(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_BIT_TICKS) begin
            bit_ticks = value[BT_W-1:0];
         end else if (idx == CSR_GAP_PERIODS) begin
            gap_periods = value[GAP_W-1:0];
         end
      endfunction

      function void arm_frame();
         if (held_code != '0 && phase == FR_IDLE) begin
            phase = FR_PRE_MARK;
            frames_started++;
         end
      endfunction

      // one segment-end tick moves the frame on
      function void advance_segment();
         case (phase)
            FR_IDLE: begin
               carrier = 1'b0;
            end
            FR_PRE_MARK: begin
               segment = SEG_W'(bit_ticks) << 3;
               carrier = 1'b1;
               phase   = FR_PRE_SPACE;
            end
            FR_PRE_SPACE: begin
               carrier    = 1'b0;
               shift_word = held_code;
               phase      = FR_BIT_MARK;
            end
            FR_BIT_MARK, FR_INV_MARK, FR_STOP: begin
               segment = SEG_W'(bit_ticks);
               carrier = 1'b1;
               if (phase == FR_BIT_MARK) begin
                  phase = FR_BIT_SPACE;
               end else if (phase == FR_INV_MARK) begin
                  phase = FR_INV_SPACE;
               end else begin
                  phase = FR_GAP;
               end
            end
            FR_BIT_SPACE, FR_INV_SPACE: begin
               carrier = 1'b0;
               segment = shift_word[CODE_BITS-1] ? SEG_W'(bit_ticks) << 2
                                                 : SEG_W'(bit_ticks) << 1;
               shift_word = shift_word << 1;
               bit_index  = bit_index + 1'b1;
               if (bit_index >= CODE_BITS) begin
                  // code word done: inverted word follows, then the stop mark
                  if (phase == FR_BIT_SPACE) begin
                     shift_word = ~held_code;
                     bit_index  = '0;
                     phase      = FR_INV_MARK;
                  end else begin
                     phase = FR_STOP;
                  end
               end else begin
                  phase = (phase == FR_BIT_SPACE) ? FR_BIT_MARK : FR_INV_MARK;
               end
            end
            FR_GAP: begin
               carrier   = 1'b0;
               segment   = SEG_W'(bit_ticks);
               gap_count = gap_count + 1'b1;
               if (gap_count >= gap_periods) begin
                  bit_index = '0;
                  gap_count = '0;
                  phase     = FR_IDLE;
               end
            end
            default: begin
               carrier = 1'b0;
               phase   = FR_IDLE;
            end
         endcase
      endfunction

      // accepted request: update state, queue the report it causes
      function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key_code);
         case (mode)
            MODE_TICK: advance_segment();
            MODE_SEND: begin
               held_code = key_code[CODE_BITS-1:0];
               arm_frame();
            end
            MODE_REPEAT: arm_frame();
            default: ;
         endcase
         pending_reports.push_back('{carrier, segment, phase != FR_IDLE});
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(logic got_carrier, logic [SEG_W-1:0] got_segment, logic got_busy);
         segment_report_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_reports.pop_front();
            compared++;
            if (got_carrier !== want.carrier) begin
               report_mismatch($sformatf("carrier_on %b, want %b", got_carrier, want.carrier));
            end
            if (got_segment !== want.segment) begin
               report_mismatch($sformatf("segment_ticks %0d, want %0d",
                                         got_segment, want.segment));
            end
            if (got_busy !== want.busy) begin
               report_mismatch($sformatf("busy_res %b, want %b", got_busy, want.busy));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;

   ircf_req_if req_chan ();
   ircf_rsp_if rsp_chan ();
   ircf_csr_if csr_chan ();

   ir_space_coded_frame_encoder DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   frame_scoreboard codes = new();

   int               issued = 0;
   int               settings_run = 0;
   int               long_stalls = 0;
   int               quiet_cycles = 0;
   bit               no_idle = 1'b0;
   bit               hold_off_req = 1'b0;
   logic [GAP_W-1:0] cur_gap = GAP_PERIODS_RST;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // known values on every input from time zero
   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.mode     = MODE_TICK;
      req_chan.key_code = '0;
      csr_chan.valid    = 1'b0;
      csr_chan.addr     = CSR_BIT_TICKS;
      csr_chan.data     = '0;
   end

   // response side: random back-pressure, one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            long_stalls++;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         codes.check_response(rsp_chan.carrier_on, rsp_chan.segment_ticks, rsp_chan.busy_res);
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request, with random idle cycles ahead of it
   task send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key_code);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.key_code <= key_code;
      do @(posedge clock); while (!req_chan.ready);
      codes.note_request(mode, key_code);
      issued++;
   endtask

   // drop valid, let every response come back and the block go quiet
   task drain_block();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (codes.pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task write_register(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      codes.configure(idx, value);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task apply_setting(input logic [BT_W-1:0] ticks, input logic [CSR_DATA_W-1:0] gap_word);
      write_register(CSR_BIT_TICKS, CSR_DATA_W'(ticks));
      write_register(CSR_GAP_PERIODS, gap_word);
      cur_gap = gap_word[GAP_W-1:0];
      settings_run++;
   endtask

   function logic [KEY_W-1:0] pick_code();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return KEY_W'(1) << (KEY_W - 1);
         2:       return KEY_W'(1);
         default: return KEY_W'($urandom_range(1, (1 << KEY_W) - 1));
      endcase
   endfunction

   // stray request: send, repeat or the unused mode
   task send_stray();
      logic [MODE_W-1:0] mode;
      mode = MODE_W'($urandom_range(int'(MODE_SEND), int'(MODE_SPARE)));
      send_request(mode, KEY_W'($urandom));
   endtask

   // start a frame and tick it through to the end, a few strays mixed in
   task run_frame();
      int ticks;
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
         send_request(MODE_SEND, pick_code());
      end else if (roll < 9) begin
         send_request(MODE_REPEAT, KEY_W'($urandom));
      end else begin
         send_request(MODE_SEND, KEY_W'($urandom));
      end
      ticks = 51 + ((cur_gap == 0) ? 1 : int'(cur_gap)) + $urandom_range(0, 3);
      repeat (ticks) begin
         if ($urandom_range(0, 24) == 0) begin
            send_stray();
         end
         send_request(MODE_TICK, KEY_W'($urandom));
      end
   endtask

   task run_noise();
      repeat ($urandom_range(1, 8)) begin
         send_request(MODE_W'($urandom_range(int'(MODE_TICK), int'(MODE_SPARE))),
                      KEY_W'($urandom));
      end
   endtask

   task run_phase(input int quota);
      int start;
      start = issued;
      while (issued - start < quota) begin
         if ($urandom_range(0, 99) < 80) begin
            run_frame();
         end else begin
            run_noise();
         end
      end
   endtask

   // stimulus
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, empty repeat, zero code, unused mode, codes changed mid-frame
      send_request(MODE_TICK, '0);
      send_request(MODE_REPEAT, '1);
      send_request(MODE_SEND, '0);
      send_request(MODE_REPEAT, '0);
      send_request(MODE_SPARE, '1);
      send_request(MODE_SPARE, '0);
      send_request(MODE_SEND, '1);
      send_request(MODE_SEND, KEY_W'('h555));
      send_request(MODE_REPEAT, '0);
      send_request(MODE_TICK, '1);
      send_request(MODE_TICK, '0);
      send_request(MODE_SEND, KEY_W'('hAAA));
      repeat (12) send_request(MODE_TICK, KEY_W'($urandom));

      // reset setting first, then extremes, random settings and the reset setting again
      run_phase(PHASE_ITEMS);
      drain_block();

      apply_setting(8'd1, CSR_DATA_W'(1));
      hold_off_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain_block();

      apply_setting(8'd255, CSR_DATA_W'(31));
      no_idle = 1'b1;
      run_phase(PHASE_ITEMS);
      no_idle = 1'b0;
      drain_block();

      apply_setting(8'd0, CSR_DATA_W'(0));
      run_phase(PHASE_ITEMS);
      drain_block();

      apply_setting(BT_W'($urandom_range(1, 255)), CSR_DATA_W'($urandom_range(0, 255)));
      run_phase(PHASE_ITEMS);
      drain_block();

      apply_setting(BT_W'($urandom_range(1, 60)), CSR_DATA_W'($urandom_range(1, 8)));
      run_phase(PHASE_ITEMS);
      drain_block();

      apply_setting(BIT_TICKS_RST, CSR_DATA_W'(GAP_PERIODS_RST));
      run_phase(PHASE_ITEMS);
      drain_block();

      $display("run covered %0d requests over %0d written settings plus reset, %0d frames",
               issued, settings_run, codes.frames_started);
      $display("%0d responses compared, %0d long receiver stalls",
               codes.compared, long_stalls);
      if (codes.errors == 0 && codes.pending_reports.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
